[hw/rtl/bcc_pkg.sv]
package bcc_pkg;

  // Elapsed-tick counter width
  localparam int TIME_WIDTH = 16;
  // Common width for comparing the counter with 16-bit timing registers
  localparam int CMP_W = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  localparam int REG_IDX_W = 4;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_CLICK_LENGTH      = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_CLICK_PAUSE       = 4'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIP_TIMEOUT       = 4'd2;
  localparam logic [REG_IDX_W-1:0] REG_LONG_FUNC_DELAY   = 4'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIM_REPEAT_TIME   = 4'd4;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_REPEAT_LIMIT = 4'd5;
  localparam logic [REG_IDX_W-1:0] REG_LOCAL_ENABLE      = 4'd6;
  localparam logic [REG_IDX_W-1:0] REG_OUTPUT_ON         = 4'd7;

  // Classifier states
  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_INITPRESS = 4'd1;
  localparam logic [3:0] ST_HOLDORTIP = 4'd2;
  localparam logic [3:0] ST_HOLD      = 4'd3;
  localparam logic [3:0] ST_TIPWAIT   = 4'd4;
  localparam logic [3:0] ST_PAUSE1    = 4'd5;
  localparam logic [3:0] ST_CLICK2    = 4'd6;
  localparam logic [3:0] ST_LONG2     = 4'd7;
  localparam logic [3:0] ST_AWAITREL  = 4'd8;
  localparam logic [3:0] ST_PAUSE2    = 4'd9;
  localparam logic [3:0] ST_LOCALDIM  = 4'd10;
  localparam logic [3:0] ST_CLICK3    = 4'd11;
  localparam logic [3:0] ST_PAUSE3    = 4'd12;

  // Event codes
  localparam logic [3:0] EV_TIP2        = 4'd1;
  localparam logic [3:0] EV_TIP3        = 4'd2;
  localparam logic [3:0] EV_HOLD_START  = 4'd4;
  localparam logic [3:0] EV_HOLD_REPEAT = 4'd5;
  localparam logic [3:0] EV_HOLD_END    = 4'd6;
  localparam logic [3:0] EV_CLICK1      = 4'd7;
  localparam logic [3:0] EV_CLICK2      = 4'd8;
  localparam logic [3:0] EV_CLICK3      = 4'd9;
  localparam logic [3:0] EV_SHORT_LONG  = 4'd10;
  localparam logic [3:0] EV_SSL         = 4'd11;
  localparam logic [3:0] EV_LOCAL_SW    = 4'd12;
  localparam logic [3:0] EV_LOCAL_DIM   = 4'd13;

  typedef struct packed {
    logic [15:0] click_length;
    logic [15:0] click_pause;
    logic [15:0] tip_timeout;
    logic [15:0] long_function_delay;
    logic [15:0] dim_repeat_time;
    logic [7:0]  hold_repeat_limit;
    logic        local_enable;
    logic        output_on;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] code;
    logic       dim_up;
  } event_t;

endpackage

[hw/rtl/bcc_fsm.sv]
// Gesture state machine: state registers plus one-item update.
module bcc_fsm (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          opcode,
  input  logic          pressed,
  input  bcc_pkg::cfg_t cfg,
  output bcc_pkg::event_t ev
);

  logic [3:0]                     st, st_next;
  logic                           level, level_next;
  logic [2:0]                     click_count, click_count_next;
  logic [7:0]                     hold_count, hold_count_next;
  logic [bcc_pkg::TIME_WIDTH-1:0] elapsed, elapsed_next;
  logic                           dim_dir, dim_dir_next;

  logic                           change, lvl, press, release_ev;
  logic [bcc_pkg::TIME_WIDTH-1:0] t_inc, dim_preload;
  logic [bcc_pkg::CMP_W-1:0]      t, c_len, c_pause, c_tip, c_long, c_dim;
  logic [3:0]                     tip_code;

  assign change     = !opcode;
  assign lvl        = change ? pressed : level;
  assign press      = change && lvl;
  assign release_ev = change && !lvl;
  assign t_inc      = (!change && elapsed != bcc_pkg::TIME_MAX) ?
                      elapsed + 1'b1 : elapsed;

  assign t       = bcc_pkg::CMP_W'(t_inc);
  assign c_len   = bcc_pkg::CMP_W'(cfg.click_length);
  assign c_pause = bcc_pkg::CMP_W'(cfg.click_pause);
  assign c_tip   = bcc_pkg::CMP_W'(cfg.tip_timeout);
  assign c_long  = bcc_pkg::CMP_W'(cfg.long_function_delay);
  assign c_dim   = bcc_pkg::CMP_W'(cfg.dim_repeat_time);

  // dim_repeat_time clipped to the counter range
  assign dim_preload = (c_dim < bcc_pkg::CMP_W'(bcc_pkg::TIME_MAX)) ?
                       bcc_pkg::TIME_WIDTH'(cfg.dim_repeat_time) : bcc_pkg::TIME_MAX;

  // tip count minus one, reported modulo 4
  assign tip_code = {2'b00, 2'(click_count - 3'd1)};

  always_comb begin
    st_next          = st;
    level_next       = lvl;
    click_count_next = click_count;
    hold_count_next  = hold_count;
    elapsed_next     = t_inc;
    dim_dir_next     = dim_dir;
    ev               = '0;
    case (st)
      bcc_pkg::ST_INITPRESS: begin
        if (release_ev) begin
          elapsed_next = '0;
          st_next      = bcc_pkg::ST_PAUSE1;
        end else if (t >= c_len) begin
          st_next = bcc_pkg::ST_HOLDORTIP;
        end
      end
      bcc_pkg::ST_HOLDORTIP: begin
        if (release_ev && click_count == 3'd0) begin
          elapsed_next     = '0;
          click_count_next = 3'd1;
          st_next          = bcc_pkg::ST_TIPWAIT;
          ev.valid         = 1'b1;
          ev.code          = bcc_pkg::EV_LOCAL_SW;
        end else if (release_ev) begin
          elapsed_next = '0;
          st_next      = bcc_pkg::ST_TIPWAIT;
          ev.valid     = 1'b1;
          ev.code      = tip_code;
        end else if (t >= c_long) begin
          if (!cfg.local_enable || !cfg.output_on) begin
            hold_count_next = '0;
            elapsed_next    = '0;
            st_next         = bcc_pkg::ST_HOLD;
            ev.valid        = 1'b1;
            ev.code         = bcc_pkg::EV_HOLD_START;
          end else begin
            // first dim step fires on the next evaluation
            dim_dir_next = !dim_dir;
            elapsed_next = dim_preload;
            st_next      = bcc_pkg::ST_LOCALDIM;
          end
        end
      end
      bcc_pkg::ST_HOLD: begin
        if (release_ev) begin
          st_next  = bcc_pkg::ST_IDLE;
          ev.valid = 1'b1;
          ev.code  = bcc_pkg::EV_HOLD_END;
        end else if (t >= c_dim) begin
          ev.valid = 1'b1;
          if (hold_count < cfg.hold_repeat_limit) begin
            elapsed_next    = '0;
            hold_count_next = hold_count + 8'd1;
            ev.code         = bcc_pkg::EV_HOLD_REPEAT;
          end else begin
            st_next = bcc_pkg::ST_AWAITREL;
            ev.code = bcc_pkg::EV_HOLD_END;
          end
        end
      end
      bcc_pkg::ST_TIPWAIT: begin
        if (press) begin
          elapsed_next     = '0;
          click_count_next = (click_count >= 3'd4) ? 3'd2 : click_count + 3'd1;
          st_next          = bcc_pkg::ST_HOLDORTIP;
        end else if (t >= c_tip) begin
          st_next = bcc_pkg::ST_IDLE;
        end
      end
      bcc_pkg::ST_PAUSE1: begin
        if (press) begin
          elapsed_next     = '0;
          click_count_next = 3'd2;
          st_next          = bcc_pkg::ST_CLICK2;
        end else if (t >= c_pause) begin
          st_next  = bcc_pkg::ST_TIPWAIT;
          ev.valid = 1'b1;
          ev.code  = cfg.local_enable ? bcc_pkg::EV_LOCAL_SW : bcc_pkg::EV_CLICK1;
        end
      end
      bcc_pkg::ST_CLICK2: begin
        if (release_ev) begin
          elapsed_next = '0;
          st_next      = bcc_pkg::ST_PAUSE2;
        end else if (t > c_len) begin
          st_next = bcc_pkg::ST_LONG2;
        end
      end
      bcc_pkg::ST_LONG2: begin
        if (release_ev) begin
          elapsed_next = '0;
          st_next      = bcc_pkg::ST_TIPWAIT;
          ev.valid     = 1'b1;
          ev.code      = bcc_pkg::EV_TIP2;
        end else if (t > c_long) begin
          st_next  = bcc_pkg::ST_AWAITREL;
          ev.valid = 1'b1;
          ev.code  = bcc_pkg::EV_SHORT_LONG;
        end
      end
      bcc_pkg::ST_PAUSE2: begin
        if (press) begin
          elapsed_next     = '0;
          click_count_next = 3'd3;
          st_next          = bcc_pkg::ST_CLICK3;
        end else if (t >= c_pause) begin
          st_next  = bcc_pkg::ST_TIPWAIT;
          ev.valid = 1'b1;
          ev.code  = bcc_pkg::EV_CLICK2;
        end
      end
      bcc_pkg::ST_CLICK3: begin
        if (release_ev) begin
          elapsed_next = '0;
          st_next      = bcc_pkg::ST_TIPWAIT;
          ev.valid     = 1'b1;
          ev.code      = bcc_pkg::EV_CLICK3;
        end else if (t >= c_len) begin
          st_next = bcc_pkg::ST_PAUSE3;
        end
      end
      bcc_pkg::ST_PAUSE3: begin
        if (release_ev) begin
          elapsed_next = '0;
          st_next      = bcc_pkg::ST_TIPWAIT;
          ev.valid     = 1'b1;
          ev.code      = bcc_pkg::EV_TIP3;
        end else if (t >= c_long) begin
          st_next  = bcc_pkg::ST_AWAITREL;
          ev.valid = 1'b1;
          ev.code  = bcc_pkg::EV_SSL;
        end
      end
      bcc_pkg::ST_LOCALDIM: begin
        if (release_ev) begin
          st_next = bcc_pkg::ST_IDLE;
        end else if (t >= c_dim) begin
          elapsed_next = '0;
          ev.valid     = 1'b1;
          ev.code      = bcc_pkg::EV_LOCAL_DIM;
          ev.dim_up    = dim_dir;
        end
      end
      bcc_pkg::ST_AWAITREL: begin
        if (release_ev) begin
          st_next = bcc_pkg::ST_IDLE;
        end
      end
      default: begin
        // idle and unused codes
        if (press) begin
          click_count_next = cfg.local_enable ? 3'd0 : 3'd1;
          elapsed_next     = '0;
          st_next          = bcc_pkg::ST_INITPRESS;
        end else begin
          st_next = bcc_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= bcc_pkg::ST_IDLE;
      level       <= 1'b0;
      click_count <= '0;
      hold_count  <= '0;
      elapsed     <= '0;
      dim_dir     <= 1'b0;
    end else if (step) begin
      st          <= st_next;
      level       <= level_next;
      click_count <= click_count_next;
      hold_count  <= hold_count_next;
      elapsed     <= elapsed_next;
      dim_dir     <= dim_dir_next;
    end
  end

endmodule

[hw/rtl/button_click_classifier.sv]
// Channel   Dir  Signals                              Word
// s_*       in   s_tvalid s_tready s_tdata[7:0]       button change or tick
// m_*       out  m_tvalid m_tready m_tdata[7:0]       one gesture event
// cfg_*     in   cfg_valid cfg_ready cfg_index cfg_data  register write
//
// Each input word is registered, then classified into the result
// register; one word per clock is sustained while m_tready does not stall.
// Words that cause no event are consumed without output.
// A stalled m_tready holds the result; the input register keeps taking
// words while the result register is free or being drained that cycle.
// rst is synchronous: state machine idle, counters zero, registers at
// their documented defaults. cfg_ready is always high.
module button_click_classifier (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: [0] opcode, [1] pressed, [7:2] zero
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,
  // m_tdata: [3:0] event_code, [4] dim_up, [7:5] zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bcc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  bcc_pkg::cfg_t   cfg;
  bcc_pkg::event_t ev;

  // input register
  logic in_full;
  logic in_opcode;
  logic in_pressed;

  // result register
  logic [3:0] out_code;
  logic       out_dim_up;

  logic advance;

  // classify the held word whenever the result register can take its event
  assign advance   = in_full && (!m_tvalid || m_tready);
  assign s_tready  = !in_full || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_opcode  <= s_tdata[0];
      in_pressed <= s_tdata[1];
    end
  end

  bcc_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .opcode  (in_opcode),
    .pressed (in_pressed),
    .cfg     (cfg),
    .ev      (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && ev.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ev.valid) begin
      out_code   <= ev.code;
      out_dim_up <= ev.dim_up;
    end
  end

  assign m_tdata = {3'b000, out_dim_up, out_code};

  // configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.click_length        <= 16'd14;
      cfg.click_pause         <= 16'd14;
      cfg.tip_timeout         <= 16'd80;
      cfg.long_function_delay <= 16'd50;
      cfg.dim_repeat_time     <= 16'd100;
      cfg.hold_repeat_limit   <= 8'd30;
      cfg.local_enable        <= 1'b0;
      cfg.output_on           <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bcc_pkg::REG_CLICK_LENGTH:      cfg.click_length        <= cfg_data;
        bcc_pkg::REG_CLICK_PAUSE:       cfg.click_pause         <= cfg_data;
        bcc_pkg::REG_TIP_TIMEOUT:       cfg.tip_timeout         <= cfg_data;
        bcc_pkg::REG_LONG_FUNC_DELAY:   cfg.long_function_delay <= cfg_data;
        bcc_pkg::REG_DIM_REPEAT_TIME:   cfg.dim_repeat_time     <= cfg_data;
        bcc_pkg::REG_HOLD_REPEAT_LIMIT: cfg.hold_repeat_limit   <= cfg_data[7:0];
        bcc_pkg::REG_LOCAL_ENABLE:      cfg.local_enable        <= cfg_data[0];
        bcc_pkg::REG_OUTPUT_ON:         cfg.output_on           <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

[test/tb.sv]
module tb;
  import bcc_pkg::*;

  // Word opcodes on the input stream
  localparam bit OP_CHANGE = 1'b0;
  localparam bit OP_TICK   = 1'b1;
  // Button levels carried by a change word
  localparam bit LVL_UP    = 1'b0;
  localparam bit LVL_DOWN  = 1'b1;
  // Tip counter wraps from four back to two
  localparam logic [2:0] TIP_COUNT_TOP = 3'd4;
  localparam logic [2:0] TIP_COUNT_RESTART = 3'd2;
  // Cycles with no accepted word at all before the run is declared hung
  localparam int STALL_LIMIT = 500;
  // Cycles to let a word with no event clear the two-stage pipe
  localparam int PIPE_FLUSH = 6;

  // How the expectation of one word is formed
  typedef enum logic [1:0] {
    CHK_MODEL,  // from the gesture predictor
    CHK_NONE,   // typed in: no event
    CHK_EVENT   // typed in: the event in the row
  } chk_e;

  typedef struct {
    logic [3:0] code;
    logic       up;
  } gesture_ev_t;

  typedef struct {
    bit                   is_reg;
    logic [REG_IDX_W-1:0] idx;
    logic [15:0]          data;
    bit                   op;
    bit                   lvl;
    chk_e                 chk;
    logic [3:0]           code;
    bit                   up;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [7:0]           s_tdata;   // [0] opcode, [1] pressed, [7:2] zero
  logic                 m_tvalid;
  logic                 m_tready;
  logic [7:0]           m_tdata;   // [3:0] event_code, [4] dim_up, [7:5] zero
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  button_click_classifier dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------
  // Gesture predictor: own copy of registers and classifier state
  // ---------------------------------------------------------------
  cfg_t                  model_cfg;
  logic [3:0]            fsm_st;
  logic                  btn_level;
  logic [2:0]            clicks;
  logic [7:0]            holds;
  logic [TIME_WIDTH-1:0] ticks_elapsed;
  logic                  dim_dir;

  gesture_ev_t pending_events[$];   // events still owed by the block

  // Checker bookkeeping
  int          errors = 0;
  int          stall_cycles = 0;
  int          words_sent = 0;
  int          events_checked = 0;
  int          reg_writes = 0;
  int          settings_used = 0;
  logic [15:0] codes_seen = '0;

  // Stimulus control shared with the monitor and the sink
  chk_e       row_chk;
  logic [3:0] row_code;
  logic       row_up;
  int         gap_pct = 25;
  int         stall_pct = 25;
  bit         calm = 0;

  dir_row_t   dir_tab[$];

  function automatic void model_reset();
    model_cfg.click_length        = 16'd14;
    model_cfg.click_pause         = 16'd14;
    model_cfg.tip_timeout         = 16'd80;
    model_cfg.long_function_delay = 16'd50;
    model_cfg.dim_repeat_time     = 16'd100;
    model_cfg.hold_repeat_limit   = 8'd30;
    model_cfg.local_enable        = 1'b0;
    model_cfg.output_on           = 1'b0;
    fsm_st        = ST_IDLE;
    btn_level     = 1'b0;
    clicks        = '0;
    holds         = '0;
    ticks_elapsed = '0;
    dim_dir       = 1'b0;
  endfunction

  function automatic void model_write(input logic [REG_IDX_W-1:0] idx,
                                      input logic [15:0] data);
    case (idx)
      REG_CLICK_LENGTH:      model_cfg.click_length = data;
      REG_CLICK_PAUSE:       model_cfg.click_pause = data;
      REG_TIP_TIMEOUT:       model_cfg.tip_timeout = data;
      REG_LONG_FUNC_DELAY:   model_cfg.long_function_delay = data;
      REG_DIM_REPEAT_TIME:   model_cfg.dim_repeat_time = data;
      REG_HOLD_REPEAT_LIMIT: model_cfg.hold_repeat_limit = data[7:0];
      REG_LOCAL_ENABLE:      model_cfg.local_enable = data[0];
      REG_OUTPUT_ON:         model_cfg.output_on = data[0];
      default: ;             // unmapped index: dropped
    endcase
  endfunction

  // Advance the classifier by one input word; returns 1 when it yields an event
  function automatic bit classify_word(input bit op, input bit lvl,
                                       output gesture_ev_t ev);
    bit              chg;
    bit              prs;
    bit              rel;
    bit              hit;
    logic [CMP_W-1:0] t;
    logic [CMP_W-1:0] dr;
    logic [2:0]       tip;
    ev.code = '0;
    ev.up   = 1'b0;
    hit     = 1'b0;
    chg     = (op == OP_CHANGE);
    // ticks bump the counter before the state looks at it; changes never do
    if (chg) btn_level = lvl;
    else if (ticks_elapsed != TIME_MAX) ticks_elapsed = ticks_elapsed + 1'b1;
    prs = chg && btn_level;
    rel = chg && !btn_level;
    t   = ticks_elapsed;
    tip = clicks - 3'd1;
    case (fsm_st)
      ST_INITPRESS: begin
        if (rel) begin
          ticks_elapsed = '0;
          fsm_st = ST_PAUSE1;
        end else if (t >= model_cfg.click_length) begin
          fsm_st = ST_HOLDORTIP;
        end
      end
      ST_HOLDORTIP: begin
        if (rel && clicks == 3'd0) begin
          ticks_elapsed = '0;
          clicks = 3'd1;
          fsm_st = ST_TIPWAIT;
          hit = 1'b1;
          ev.code = EV_LOCAL_SW;
        end else if (rel) begin
          ticks_elapsed = '0;
          fsm_st = ST_TIPWAIT;
          hit = 1'b1;
          ev.code = {2'b00, tip[1:0]};
        end else if (t >= model_cfg.long_function_delay) begin
          if (!model_cfg.local_enable || !model_cfg.output_on) begin
            holds = '0;
            ticks_elapsed = '0;
            fsm_st = ST_HOLD;
            hit = 1'b1;
            ev.code = EV_HOLD_START;
          end else begin
            // local dim: flip direction, preload so the first step is due
            dim_dir = ~dim_dir;
            dr = model_cfg.dim_repeat_time;
            ticks_elapsed = (dr < TIME_MAX) ? dr[TIME_WIDTH-1:0] : TIME_MAX;
            fsm_st = ST_LOCALDIM;
          end
        end
      end
      ST_HOLD: begin
        if (rel) begin
          fsm_st = ST_IDLE;
          hit = 1'b1;
          ev.code = EV_HOLD_END;
        end else if (t >= model_cfg.dim_repeat_time) begin
          hit = 1'b1;
          if (holds < model_cfg.hold_repeat_limit) begin
            ticks_elapsed = '0;
            holds = holds + 8'd1;
            ev.code = EV_HOLD_REPEAT;
          end else begin
            fsm_st = ST_AWAITREL;
            ev.code = EV_HOLD_END;
          end
        end
      end
      ST_TIPWAIT: begin
        if (prs) begin
          ticks_elapsed = '0;
          clicks = (clicks >= TIP_COUNT_TOP) ? TIP_COUNT_RESTART : clicks + 3'd1;
          fsm_st = ST_HOLDORTIP;
        end else if (t >= model_cfg.tip_timeout) begin
          fsm_st = ST_IDLE;
        end
      end
      ST_PAUSE1: begin
        if (prs) begin
          ticks_elapsed = '0;
          clicks = 3'd2;
          fsm_st = ST_CLICK2;
        end else if (t >= model_cfg.click_pause) begin
          fsm_st = ST_TIPWAIT;
          hit = 1'b1;
          ev.code = model_cfg.local_enable ? EV_LOCAL_SW : EV_CLICK1;
        end
      end
      ST_CLICK2: begin
        if (rel) begin
          ticks_elapsed = '0;
          fsm_st = ST_PAUSE2;
        end else if (t > model_cfg.click_length) begin
          fsm_st = ST_LONG2;
        end
      end
      ST_LONG2: begin
        if (rel) begin
          ticks_elapsed = '0;
          fsm_st = ST_TIPWAIT;
          hit = 1'b1;
          ev.code = EV_TIP2;
        end else if (t > model_cfg.long_function_delay) begin
          fsm_st = ST_AWAITREL;
          hit = 1'b1;
          ev.code = EV_SHORT_LONG;
        end
      end
      ST_PAUSE2: begin
        if (prs) begin
          ticks_elapsed = '0;
          clicks = 3'd3;
          fsm_st = ST_CLICK3;
        end else if (t >= model_cfg.click_pause) begin
          fsm_st = ST_TIPWAIT;
          hit = 1'b1;
          ev.code = EV_CLICK2;
        end
      end
      ST_CLICK3: begin
        if (rel) begin
          ticks_elapsed = '0;
          fsm_st = ST_TIPWAIT;
          hit = 1'b1;
          ev.code = EV_CLICK3;
        end else if (t >= model_cfg.click_length) begin
          fsm_st = ST_PAUSE3;
        end
      end
      ST_PAUSE3: begin
        // third press held: a release still counts as three tips
        if (rel) begin
          ticks_elapsed = '0;
          fsm_st = ST_TIPWAIT;
          hit = 1'b1;
          ev.code = EV_TIP3;
        end else if (t >= model_cfg.long_function_delay) begin
          fsm_st = ST_AWAITREL;
          hit = 1'b1;
          ev.code = EV_SSL;
        end
      end
      ST_LOCALDIM: begin
        if (rel) begin
          fsm_st = ST_IDLE;
        end else if (t >= model_cfg.dim_repeat_time) begin
          ticks_elapsed = '0;
          hit = 1'b1;
          ev.code = EV_LOCAL_DIM;
          ev.up = dim_dir;
        end
      end
      ST_AWAITREL: begin
        if (rel) fsm_st = ST_IDLE;
      end
      default: begin
        // idle, and the unused codes act as idle
        if (prs) begin
          clicks = model_cfg.local_enable ? 3'd0 : 3'd1;
          ticks_elapsed = '0;
          fsm_st = ST_INITPRESS;
        end else begin
          fsm_st = ST_IDLE;
        end
      end
    endcase
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Compare one output word with the oldest owed event
  task automatic check_event(input logic [7:0] word);
    gesture_ev_t want;
    if (pending_events.size() == 0) begin
      report_mismatch($sformatf("event code %0d with none owed", word[3:0]));
    end else begin
      want = pending_events.pop_front();
      events_checked++;
      codes_seen[word[3:0]] = 1'b1;
      if (word[3:0] !== want.code)
        report_mismatch($sformatf("event_code %0d, want %0d", word[3:0], want.code));
      if (word[4] !== want.up)
        report_mismatch($sformatf("dim_up %0b, want %0b (code %0d)",
                                  word[4], want.up, want.code));
    end
  endtask

  // ---------------------------------------------------------------
  // Clock, and the monitor: everything sampled at the rising edge
  // ---------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : monitor
    bit          moved;
    bit          hit;
    gesture_ev_t ev;
    if (rst) begin
      model_reset();
      stall_cycles = 0;
    end else begin
      moved = 1'b0;
      // result side first; a word taken this edge cannot show up yet
      if (m_tvalid && m_tready) begin
        check_event(m_tdata);
        moved = 1'b1;
      end
      if (s_tvalid && s_tready) begin
        hit = classify_word(s_tdata[0], s_tdata[1], ev);
        case (row_chk)
          CHK_EVENT: begin
            ev.code = row_code;
            ev.up = row_up;
            pending_events.push_back(ev);
          end
          CHK_NONE: ;
          default: if (hit) pending_events.push_back(ev);
        endcase
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        model_write(cfg_index, cfg_data);
        reg_writes++;
        moved = 1'b1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog: too long without any word moving anywhere
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------
  // Result sink: random stall bursts, always ready once calm
  // ---------------------------------------------------------------
  initial begin : sink
    int  n;
    bit  v;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (calm) begin
        v = 1'b1;
        n = 1;
      end else if ($urandom_range(99) < stall_pct) begin
        v = 1'b0;
        n = $urandom_range(1, 18);
      end else begin
        v = 1'b1;
        n = $urandom_range(1, 40);
      end
      m_tready <= v;
      repeat (n) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------
  // Stimulus tasks; each starts and ends on a falling edge
  // ---------------------------------------------------------------
  task automatic send_word(input bit op, input bit lvl, input chk_e chk,
                           input logic [3:0] code, input bit up);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, lvl, op};
    row_chk  <= chk;
    row_code <= code;
    row_up   <= up;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (!calm && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every owed event is out and the pipe is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (PIPE_FLUSH) @(negedge clk);
  endtask

  task automatic use_setting(input int cl, input int cp, input int tt, input int lfd,
                             input int drt, input int mhr, input int le, input int oo);
    settle();
    write_reg(REG_CLICK_LENGTH,      16'(cl));
    write_reg(REG_CLICK_PAUSE,       16'(cp));
    write_reg(REG_TIP_TIMEOUT,       16'(tt));
    write_reg(REG_LONG_FUNC_DELAY,   16'(lfd));
    write_reg(REG_DIM_REPEAT_TIME,   16'(drt));
    write_reg(REG_HOLD_REPEAT_LIMIT, 16'(mhr));
    write_reg(REG_LOCAL_ENABLE,      16'(le));
    write_reg(REG_OUTPUT_ON,         16'(oo));
    settings_used++;
  endtask

  // Short timings so that every branch is reachable in a few ticks
  task automatic random_small_setting();
    use_setting($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6),
                $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 3),
                $urandom_range(1), $urandom_range(1));
  endtask

  function automatic int pick_len(input int lim);
    if ($urandom_range(3) == 0) return $urandom_range(0, 3 * lim);
    return $urandom_range(0, lim);
  endfunction

  // ticks carry a random level bit, which the block must ignore
  task automatic tick_run(input int n);
    repeat (n) send_word(OP_TICK, 1'($urandom_range(1)), CHK_MODEL, '0, 1'b0);
  endtask

  // stray words: repeated levels, lone ticks, out-of-order edges
  task automatic noise();
    repeat ($urandom_range(1, 4))
      send_word(1'($urandom_range(1)), 1'($urandom_range(1)), CHK_MODEL, '0, 1'b0);
  endtask

  // One gesture: up to four press/release pairs with random hold and pause
  task automatic gesture(input int lim);
    int presses;
    presses = $urandom_range(1, 4);
    if ($urandom_range(9) == 0) noise();
    repeat (presses) begin
      send_word(OP_CHANGE, LVL_DOWN, CHK_MODEL, '0, 1'b0);
      tick_run(pick_len(lim));
      if ($urandom_range(19) == 0) noise();
      send_word(OP_CHANGE, LVL_UP, CHK_MODEL, '0, 1'b0);
      tick_run(pick_len(lim));
    end
  endtask

  // budget is checked between gestures, so a phase runs a little long
  task automatic run_phase(input int budget, input int lim, input int gaps);
    int stop;
    gap_pct   = gaps;
    stall_pct = gaps;
    stop = words_sent + budget;
    while (words_sent < stop) gesture(lim);
  endtask

  task automatic add_word(input bit op, input bit lvl, input chk_e chk,
                          input logic [3:0] code, input bit up);
    dir_row_t r;
    r.is_reg = 1'b0;
    r.idx    = '0;
    r.data   = '0;
    r.op     = op;
    r.lvl    = lvl;
    r.chk    = chk;
    r.code   = code;
    r.up     = up;
    dir_tab.push_back(r);
  endtask

  task automatic add_reg(input logic [REG_IDX_W-1:0] idx, input int data);
    dir_row_t r;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.data   = 16'(data);
    r.op     = OP_TICK;
    r.lvl    = LVL_UP;
    r.chk    = CHK_MODEL;
    r.code   = '0;
    r.up     = 1'b0;
    dir_tab.push_back(r);
  endtask

  // Directed rows: typed events where the trace is plain, the predictor elsewhere
  task automatic build_directed();
    // straight after reset a tick in idle does nothing
    add_word(OP_TICK, LVL_UP, CHK_NONE, '0, 1'b0);
    // short timings: click 1, pause 1, tip timeout 3, long 2, repeat 1
    add_reg(REG_CLICK_LENGTH, 1);
    add_reg(REG_CLICK_PAUSE, 1);
    add_reg(REG_TIP_TIMEOUT, 3);
    add_reg(REG_LONG_FUNC_DELAY, 2);
    add_reg(REG_DIM_REPEAT_TIME, 1);
    add_reg(REG_HOLD_REPEAT_LIMIT, 1);
    add_reg(REG_LOCAL_ENABLE, 0);
    add_reg(REG_OUTPUT_ON, 0);
    // single click, then the tip window times out
    add_word(OP_CHANGE, LVL_DOWN, CHK_NONE, '0, 1'b0);
    add_word(OP_CHANGE, LVL_UP, CHK_NONE, '0, 1'b0);
    add_word(OP_TICK, LVL_UP, CHK_EVENT, EV_CLICK1, 1'b0);
    add_word(OP_TICK, LVL_UP, CHK_NONE, '0, 1'b0);
    add_word(OP_TICK, LVL_UP, CHK_NONE, '0, 1'b0);
    // hold: start, one repeat, forced end, release from await state
    add_word(OP_CHANGE, LVL_DOWN, CHK_NONE, '0, 1'b0);
    add_word(OP_TICK, LVL_UP, CHK_NONE, '0, 1'b0);
    add_word(OP_TICK, LVL_UP, CHK_EVENT, EV_HOLD_START, 1'b0);
    add_word(OP_TICK, LVL_UP, CHK_EVENT, EV_HOLD_REPEAT, 1'b0);
    add_word(OP_TICK, LVL_UP, CHK_EVENT, EV_HOLD_END, 1'b0);
    add_word(OP_CHANGE, LVL_UP, CHK_NONE, '0, 1'b0);
    // local key mode with the output on
    add_reg(REG_LOCAL_ENABLE, 1);
    add_reg(REG_OUTPUT_ON, 1);
    // long press enters local dim; preloaded count gives a step at once
    add_word(OP_CHANGE, LVL_DOWN, CHK_MODEL, '0, 1'b0);
    add_word(OP_TICK, LVL_UP, CHK_MODEL, '0, 1'b0);
    add_word(OP_TICK, LVL_UP, CHK_MODEL, '0, 1'b0);
    add_word(OP_TICK, LVL_DOWN, CHK_MODEL, '0, 1'b0);
    add_word(OP_CHANGE, LVL_UP, CHK_MODEL, '0, 1'b0);
    // local switch, then quick tips until the counter wraps
    add_word(OP_CHANGE, LVL_DOWN, CHK_MODEL, '0, 1'b0);
    add_word(OP_TICK, LVL_UP, CHK_MODEL, '0, 1'b0);
    add_word(OP_CHANGE, LVL_UP, CHK_MODEL, '0, 1'b0);
    repeat (4) begin
      add_word(OP_CHANGE, LVL_DOWN, CHK_MODEL, '0, 1'b0);
      add_word(OP_CHANGE, LVL_UP, CHK_MODEL, '0, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin : stimulus
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    row_chk   = CHK_MODEL;
    row_code  = '0;
    row_up    = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    build_directed();
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_word(dir_tab[i].op, dir_tab[i].lvl, dir_tab[i].chk,
                  dir_tab[i].code, dir_tab[i].up);
      end
    end
    settings_used++;

    // random gestures under a range of timings
    random_small_setting();
    run_phase(200, 8, 25);
    random_small_setting();
    run_phase(170, 8, 0);          // back-to-back words, sink never stalls
    random_small_setting();
    run_phase(170, 8, 40);
    // all timings zero: every timed check but the strict ones fires on first look
    use_setting(0, 0, 0, 0, 0, 0, 1, 1);
    run_phase(80, 3, 25);
    // all timings at full scale, plus writes to unmapped indexes
    use_setting(65535, 65535, 65535, 65535, 65535, 255, 1, 0);
    write_reg(REG_OUTPUT_ON + 4'($urandom_range(1, 8)), 16'($urandom));
    write_reg(REG_OUTPUT_ON + 4'($urandom_range(1, 8)), 16'($urandom));
    run_phase(80, 8, 25);
    // power-up timings, remote then local mode
    use_setting(14, 14, 80, 50, 100, 30, 0, 0);
    run_phase(240, 20, 25);
    use_setting(14, 14, 80, 50, 100, 30, 1, 1);
    run_phase(160, 20, 25);
    // closing stretch with no idling on either side
    random_small_setting();
    calm = 1'b1;
    run_phase(170, 6, 0);

    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("run covered %0d input words, %0d events, %0d register writes, %0d settings",
             words_sent, events_checked, reg_writes, settings_used);
    $display("event codes seen, one bit per code: %b", codes_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[button_click_classifier.f]
hw/rtl/bcc_pkg.sv
hw/rtl/bcc_fsm.sv
hw/rtl/button_click_classifier.sv
test/tb.sv
